FILE: sv/rkec_pkg.sv
// ----------------------------------------------------------------------------
// rkec_pkg
// Shared types, register indexes, event codes and the encoder phase table
// for the rotary knob event controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rkec_pkg;

  // configuration register width and index field
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // default timer width
  localparam int TIMER_BITS_DEF = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_SLEEP     = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] FLUSH_PERIOD_RST  = 24'd50;
  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 24'd30;
  localparam logic [CFG_W-1:0] SHORT_PRESS_RST   = 24'd400;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 24'd800;
  localparam logic [CFG_W-1:0] IDLE_SLEEP_RST    = 24'd60000;

  // event kinds
  localparam logic [1:0] KIND_BRIGHT = 2'd0;
  localparam logic [1:0] KIND_TEMP   = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;
  localparam logic [1:0] KIND_SLEEP  = 2'd3;

  // detent step codes
  localparam logic [1:0] STEP_HOLD = 2'd0;
  localparam logic [1:0] STEP_DEC  = 2'd1;
  localparam logic [1:0] STEP_INC  = 2'd2;
  localparam logic [1:0] STEP_SKIP = 2'd3;

  // idle phase code with pull-ups
  localparam logic [1:0] PHASE_DETENT = 2'd3;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic button_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [7:0]         sequence_res;
    logic signed [15:0] delta_value;
    logic               wake_pol;
    logic               last_of_tick;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] flush_period;
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] short_press_limit;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] idle_sleep_time;
  } cfg_t;

  // results of one tick, packed from index 0
  typedef struct packed {
    out_item_t [2:0] item;
    logic [1:0]      count;
  } grp_t;

  // quadrature transition table: previous phase, new phase -> step code
  function automatic logic [1:0] phase_step(input logic [1:0] prev, input logic [1:0] nxt);
    logic [1:0] code;
    code = STEP_HOLD;
    case ({prev, nxt})
      4'b00_11: code = STEP_SKIP;
      4'b01_10: code = STEP_SKIP;
      4'b01_11: code = STEP_DEC;
      4'b10_01: code = STEP_SKIP;
      4'b10_11: code = STEP_INC;
      4'b11_00: code = STEP_SKIP;
      default:  code = STEP_HOLD;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rkec_tick.sv
// ----------------------------------------------------------------------------
// rkec_tick
// Knob state registers and the one-tick update: encoder accumulation, delta
// flush, button debounce and press timing, long press and idle sleep timers.
// ----------------------------------------------------------------------------
`default_nettype none

module rkec_tick #(
  parameter int TIMER_BITS = rkec_pkg::TIMER_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire rkec_pkg::in_item_t item,
  input  wire rkec_pkg::cfg_t    cfg,
  output rkec_pkg::grp_t         grp
);
  import rkec_pkg::*;

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [CW-1:0] TMAX_W = CW'((65'd1 << TIMER_BITS) - 65'd1);
  localparam logic [TIMER_BITS-1:0] TMAX_T = {TIMER_BITS{1'b1}};
  localparam logic [TIMER_BITS-1:0] T_ZERO = '0;

  // saturate a register value into the timer range
  function automatic logic [TIMER_BITS-1:0] clamp_t(input logic [CFG_W-1:0] v);
    logic [CW-1:0] vx;
    vx = CW'(v);
    if (vx > TMAX_W) vx = TMAX_W;
    return TIMER_BITS'(vx);
  endfunction

  logic [1:0]            phase_r, phase_nxt;
  logic signed [15:0]    acc_r, acc_nxt;
  logic [TIMER_BITS-1:0] flush_el_r, flush_el_nxt;
  logic                  btn_prev_r, btn_prev_nxt;
  logic [TIMER_BITS-1:0] since_r, since_nxt;
  logic                  armed_r, armed_nxt;
  logic [TIMER_BITS-1:0] long_rem_r, long_rem_nxt;
  logic [TIMER_BITS-1:0] sleep_rem_r, sleep_rem_nxt;
  logic                  mode_r, mode_nxt;
  logic [7:0]            seq_r, seq_nxt;

  logic [1:0]            step;
  logic signed [15:0]    acc_step;
  logic [TIMER_BITS-1:0] flush_inc, since_inc;
  logic                  emit_delta, emit_long, emit_sleep, restart;
  logic                  since_deb, since_short;
  logic signed [15:0]    delta_out;
  logic [7:0]            seq_long;

  // encoder step with saturation
  always_comb begin
    step     = phase_step(phase_r, {item.enc_a, item.enc_b});
    acc_step = acc_r;
    case (step)
      STEP_INC: if (acc_r != 16'sh7FFF) acc_step = acc_r + 16'sd1;
      STEP_DEC: if (acc_r != 16'sh8000) acc_step = acc_r - 16'sd1;
      default:  acc_step = acc_r;
    endcase
  end

  assign flush_inc   = (flush_el_r == TMAX_T) ? TMAX_T : flush_el_r + 1'b1;
  assign since_inc   = (since_r == TMAX_T) ? TMAX_T : since_r + 1'b1;
  assign since_deb   = CW'(since_inc) >= CW'(cfg.debounce_time);
  assign since_short = CW'(since_inc) < CW'(cfg.short_press_limit);

  // tick update
  always_comb begin
    phase_nxt     = {item.enc_a, item.enc_b};
    acc_nxt       = acc_step;
    flush_el_nxt  = flush_inc;
    btn_prev_nxt  = item.button_level;
    since_nxt     = since_inc;
    armed_nxt     = armed_r;
    long_rem_nxt  = long_rem_r;
    sleep_rem_nxt = sleep_rem_r;
    mode_nxt      = mode_r;
    emit_delta    = 1'b0;
    emit_long     = 1'b0;
    emit_sleep    = 1'b0;
    restart       = 1'b0;
    delta_out     = acc_step;

    // delta flush
    if (CW'(flush_inc) >= CW'(cfg.flush_period)) begin
      flush_el_nxt = T_ZERO;
      if (acc_step != 16'sd0) begin
        emit_delta = 1'b1;
        acc_nxt    = 16'sd0;
        restart    = 1'b1;
      end
    end

    // long press countdown
    if (long_rem_r != T_ZERO) begin
      long_rem_nxt = long_rem_r - 1'b1;
      if (long_rem_r == TIMER_BITS'(1)) begin
        emit_long = 1'b1;
        restart   = 1'b1;
      end
    end

    // idle countdown
    if (sleep_rem_r != T_ZERO) begin
      sleep_rem_nxt = sleep_rem_r - 1'b1;
      if (sleep_rem_r == TIMER_BITS'(1)) emit_sleep = 1'b1;
    end

    // button edges
    if (item.button_level != btn_prev_r) begin
      if (!item.button_level) begin
        if (since_deb) begin
          since_nxt = T_ZERO;
          if (!armed_r) begin
            armed_nxt    = 1'b1;
            long_rem_nxt = clamp_t(cfg.long_press_time);
          end
        end
      end else begin
        if (armed_r) begin
          armed_nxt    = 1'b0;
          long_rem_nxt = T_ZERO;
          restart      = 1'b1;
        end
        if (since_deb && since_short) begin
          mode_nxt = ~mode_r;
          restart  = 1'b1;
        end
      end
    end

    if (restart) sleep_rem_nxt = clamp_t(cfg.idle_sleep_time);

    seq_nxt = seq_r + {7'd0, emit_delta} + {7'd0, emit_long};
  end

  assign seq_long = seq_r + {7'd0, emit_delta};

  // pack results in delta, long press, sleep order
  always_comb begin
    out_item_t d_item, l_item, s_item;
    d_item.event_kind   = mode_r ? KIND_TEMP : KIND_BRIGHT;
    d_item.sequence_res = seq_r;
    d_item.delta_value  = delta_out;
    d_item.wake_pol     = 1'b0;
    d_item.last_of_tick = !emit_long && !emit_sleep;
    l_item.event_kind   = KIND_LONG;
    l_item.sequence_res = seq_long;
    l_item.delta_value  = 16'sd1;
    l_item.wake_pol     = 1'b0;
    l_item.last_of_tick = !emit_sleep;
    s_item.event_kind   = KIND_SLEEP;
    s_item.sequence_res = 8'd0;
    s_item.delta_value  = 16'sd0;
    s_item.wake_pol     = ~item.enc_a;
    s_item.last_of_tick = 1'b1;

    grp.count = {1'b0, emit_delta} + {1'b0, emit_long} + {1'b0, emit_sleep};
    grp.item  = {s_item, s_item, s_item};
    case ({emit_delta, emit_long})
      2'b11: begin
        grp.item[0] = d_item;
        grp.item[1] = l_item;
      end
      2'b10: grp.item[0] = d_item;
      2'b01: grp.item[0] = l_item;
      default: grp.item[0] = s_item;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_DETENT;
      acc_r       <= 16'sd0;
      flush_el_r  <= T_ZERO;
      btn_prev_r  <= 1'b1;
      since_r     <= TMAX_T;
      armed_r     <= 1'b0;
      long_rem_r  <= T_ZERO;
      sleep_rem_r <= clamp_t(IDLE_SLEEP_RST);
      mode_r      <= 1'b0;
      seq_r       <= 8'd0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      flush_el_r  <= flush_el_nxt;
      btn_prev_r  <= btn_prev_nxt;
      since_r     <= since_nxt;
      armed_r     <= armed_nxt;
      long_rem_r  <= long_rem_nxt;
      sleep_rem_r <= sleep_rem_nxt;
      mode_r      <= mode_nxt;
      seq_r       <= seq_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rotary_knob_event_controller_core.sv
// ----------------------------------------------------------------------------
// rotary_knob_event_controller_core
// Top level: configuration registers, tick input register, tick update and a
// three-entry result buffer that hands results out one beat at a time.
// ----------------------------------------------------------------------------
// One input beat is one tick of encoder and button samples. A tick sits in
// the input register until the result buffer is free, is then applied to the
// knob state and its zero to three results land in the result buffer, from
// which the first result is offered. Ticks that cause at most one result flow
// at one per cycle while out_ready stays high; a tick that causes several
// results keeps the following tick waiting in the input register while the
// result buffer drains one beat per cycle, as out_ready allows. The result
// buffer drain is what sets the rate. Configuration writes take effect on
// the next cycle and are meant for idle periods.
`default_nettype none

module rotary_knob_event_controller_core #(
  parameter int TIMER_BITS = rkec_pkg::TIMER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rkec_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rkec_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [rkec_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rkec_pkg::CFG_W-1:0]     cfg_data
);
  import rkec_pkg::*;

  cfg_t            cfg_r;
  in_item_t        in_item_r;
  logic            in_v_r;
  out_item_t [2:0] buf_r;
  logic [1:0]      cnt_r;
  grp_t            tick_grp;
  logic            out_fire, buf_free, advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flush_period      <= FLUSH_PERIOD_RST;
      cfg_r.debounce_time     <= DEBOUNCE_TIME_RST;
      cfg_r.short_press_limit <= SHORT_PRESS_RST;
      cfg_r.long_press_time   <= LONG_PRESS_RST;
      cfg_r.idle_sleep_time   <= IDLE_SLEEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FLUSH_PERIOD:  cfg_r.flush_period      <= cfg_data;
        REG_DEBOUNCE_TIME: cfg_r.debounce_time     <= cfg_data;
        REG_SHORT_PRESS:   cfg_r.short_press_limit <= cfg_data;
        REG_LONG_PRESS:    cfg_r.long_press_time   <= cfg_data;
        REG_IDLE_SLEEP:    cfg_r.idle_sleep_time   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = buf_r[0];
  assign out_fire  = out_valid && out_ready;
  assign buf_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire);
  assign advance   = in_v_r && buf_free;
  assign in_ready  = !in_v_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // tick update
  rkec_tick #(
    .TIMER_BITS (TIMER_BITS)
  ) u_tick (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .grp   (tick_grp)
  );

  // result buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (advance) begin
      cnt_r <= tick_grp.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // result buffer payload, head at entry 0
  always_ff @(posedge clk) begin
    if (advance) begin
      buf_r <= tick_grp.item;
    end else if (out_fire) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

`ifndef NO_ASSERTIONS
  // a tick with results shows its first result next cycle
  a_grp_shown: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (tick_grp.count != 2'd0) |=> out_valid)
    else $error("tick results not presented");

  // a held tick stays in the input register
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !buf_free |=> in_v_r && $stable(in_item_r))
    else $error("pending tick lost");

  // the last buffered result closes the tick
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r == 2'd1) |-> out_data.last_of_tick)
    else $error("final result not marked");

  // earlier results of a tick are not marked last
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r != 2'd1) |-> !out_data.last_of_tick)
    else $error("result marked last too early");

  // draining the final result without a new tick empties the buffer
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && (cnt_r == 2'd1) && !advance |=> !out_valid)
    else $error("result repeated");
`endif

endmodule

`default_nettype wire
